FILE: rtl/stia_pkg.sv
package stia_pkg;

   // Payload widths
   localparam int unsigned CharWidth  = 8;
   localparam int unsigned ValueWidth = 64;
   localparam int unsigned PosWidth   = 16;
   localparam int unsigned BaseWidth  = 6;

   // Saturation point of the character position counters
   localparam logic [PosWidth-1:0] MaxLen = 16'hFFFF;

   // Base limits and special digit codes
   localparam logic [BaseWidth-1:0] MaxBase   = 6'd36;
   localparam logic [BaseWidth-1:0] DigitNone = 6'd37;   // never below any base
   localparam logic [BaseWidth-1:0] BaseAuto  = 6'd0;
   localparam logic [BaseWidth-1:0] BaseBin   = 6'd2;
   localparam logic [BaseWidth-1:0] BaseOct   = 6'd8;
   localparam logic [BaseWidth-1:0] BaseDec   = 6'd10;
   localparam logic [BaseWidth-1:0] BaseHex   = 6'd16;

   // Configuration register indexes
   localparam logic CsrRadix      = 1'b0;
   localparam logic CsrSkipSpaces = 1'b1;

   // Character codes
   localparam logic [CharWidth-1:0] ChSpace = 8'h20;
   localparam logic [CharWidth-1:0] ChTab   = 8'h09;
   localparam logic [CharWidth-1:0] ChCr    = 8'h0D;
   localparam logic [CharWidth-1:0] ChPlus  = 8'h2B;
   localparam logic [CharWidth-1:0] ChMinus = 8'h2D;
   localparam logic [CharWidth-1:0] ChZero  = 8'h30;
   localparam logic [CharWidth-1:0] ChNine  = 8'h39;
   localparam logic [CharWidth-1:0] ChUpA   = 8'h41;
   localparam logic [CharWidth-1:0] ChUpZ   = 8'h5A;
   localparam logic [CharWidth-1:0] ChLoA   = 8'h61;
   localparam logic [CharWidth-1:0] ChLoZ   = 8'h7A;
   localparam logic [CharWidth-1:0] ChUpX   = 8'h58;
   localparam logic [CharWidth-1:0] ChLoX   = 8'h78;
   localparam logic [CharWidth-1:0] ChUpB   = 8'h42;
   localparam logic [CharWidth-1:0] ChLoB   = 8'h62;

   // Input beat
   typedef struct packed {
      logic [CharWidth-1:0] ch;
      logic                 last;
   } req_type;

   // Result beat
   typedef struct packed {
      logic signed [ValueWidth-1:0] value;
      logic [PosWidth-1:0]          stop_offset;
   } rsp_type;

   // Character class flags from the decoder
   typedef struct packed {
      logic                 is_white;
      logic                 is_plus;
      logic                 is_minus;
      logic                 is_zero;
      logic                 is_x;
      logic                 is_b;
      logic [BaseWidth-1:0] digit;
   } char_class_type;

endpackage

FILE: rtl/string_to_integer_any_base_top.sv
// String to integer converter, bases 2 to 36 with prefix detection.
// Input channel (req_): one character per beat in req_data.ch, with
// req_data.last set on the final character of a string. Every string
// yields exactly one result beat on the rsp_ channel: the parsed value
// (two's complement, wrapping modulo 2^64) and the count of characters
// consumed before parsing stopped (saturating at 65535).
// Configuration (csr_): radix (index 0, 0 = detect from prefix, above 36
// acts as 36) and skip_spaces (index 1). Write only between strings;
// the radix is sampled on the first character of each string.
// Throughput: one character per cycle while the input is not stalled.
// Each beat is registered at the input, then the parse state (and, for
// a last character, the result register) is updated from it by one
// 64 x 6 multiply-accumulate; results are driven on rsp_ from that register.
// A stalled result holds its beat; characters that produce no result
// keep flowing, and the input stalls only when a last character must
// wait for the result register.
// Reset (synchronous, active high) clears the parse state and the valid
// flags of both pipeline registers, and sets radix to 10 and skip_spaces to 0.
module string_to_integer_any_base_top
   import stia_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_wr_en,
   input  logic                 csr_index,
   input  logic [BaseWidth-1:0] csr_wdata
);

   typedef enum logic [1:0] {
      PhSpace,
      PhSign,
      PhDigits,
      PhDone
   } phase_type;

   // Configuration registers
   logic [BaseWidth-1:0] radix_ff;
   logic                 skip_ff;

   // Input stage
   logic    in_valid_ff;
   req_type in_data_ff;

   // Parse state
   phase_type              phase_ff, phase_in;
   logic                   neg_ff, neg_in;
   logic [ValueWidth-1:0]  acc_ff, acc_in;
   logic [BaseWidth-1:0]   base_ff, base_in;
   logic                   pz_ff, pz_in;
   logic [PosWidth-1:0]    pos_ff, pos_in;
   logic [PosWidth-1:0]    stop_ff, stop_in;

   // Result stage
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff, rsp_data_in;

   char_class_type       cls;
   logic                 advance;
   logic                 taken;
   logic [PosWidth-1:0]  next_pos;
   logic [ValueWidth-1:0] mac;

   stia_char_class u_class (
      .ch  (in_data_ff.ch),
      .cls (cls)
   );

   // Handshake: a last character needs room in the result register
   assign advance   = in_valid_ff && (!in_data_ff.last || !rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign next_pos = (pos_ff == MaxLen) ? MaxLen : pos_ff + 1'b1;

   // Parse step for the registered character
   always_comb begin
      phase_in = phase_ff;
      neg_in   = neg_ff;
      acc_in   = acc_ff;
      pz_in    = pz_ff;
      stop_in  = stop_ff;
      pos_in   = next_pos;
      taken    = 1'b0;
      mac      = '0;
      base_in  = base_ff;

      // base latched on the first character of a string
      if (pos_ff == '0 && phase_ff == PhSpace) begin
         base_in = (radix_ff > MaxBase) ? MaxBase : radix_ff;
      end

      if (phase_in == PhSpace) begin
         if (skip_ff && cls.is_white) begin
            stop_in = next_pos;
            taken   = 1'b1;
         end else begin
            phase_in = PhSign;
         end
      end

      // sign run
      if (!taken && phase_in == PhSign) begin
         if (cls.is_minus) begin
            neg_in  = !neg_ff;
            stop_in = next_pos;
            taken   = 1'b1;
         end else if (cls.is_plus) begin
            stop_in = next_pos;
            taken   = 1'b1;
         end else begin
            phase_in = PhDigits;
            if (cls.is_zero && (base_in == BaseAuto || base_in == BaseHex ||
                                base_in == BaseBin)) begin
               pz_in   = 1'b1;
               stop_in = next_pos;
               taken   = 1'b1;
            end else if (base_in == BaseAuto) begin
               base_in = BaseDec;
            end
         end
      end

      // prefix letter after a leading zero, then digits
      if (!taken && phase_in == PhDigits) begin
         if (pz_ff) begin
            pz_in = 1'b0;
            if (cls.is_x && (base_in == BaseAuto || base_in == BaseHex)) begin
               base_in = BaseHex;
               stop_in = next_pos;
               taken   = 1'b1;
            end else if (cls.is_b && (base_in == BaseAuto || base_in == BaseBin)) begin
               base_in = BaseBin;
               stop_in = next_pos;
               taken   = 1'b1;
            end else if (base_in == BaseAuto) begin
               base_in = BaseOct;
            end
         end
         if (!taken) begin
            if (cls.digit < base_in) begin
               mac     = acc_ff * {{(ValueWidth-BaseWidth){1'b0}}, base_in};
               acc_in  = mac + {{(ValueWidth-BaseWidth){1'b0}}, cls.digit};
               stop_in = next_pos;
            end else begin
               phase_in = PhDone;
            end
         end
      end

      rsp_data_in.value       = neg_in ? (~acc_in + 1'b1) : acc_in;
      rsp_data_in.stop_offset = stop_in;
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= BaseDec;
         skip_ff  <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CsrRadix:      radix_ff <= csr_wdata;
            CsrSkipSpaces: skip_ff  <= csr_wdata[0];
            default:       radix_ff <= radix_ff;
         endcase
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && !req_stall) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data;
      end
   end

   // Parse state: back to start after each last character
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PhSpace;
         neg_ff   <= 1'b0;
         acc_ff   <= '0;
         base_ff  <= '0;
         pz_ff    <= 1'b0;
         pos_ff   <= '0;
         stop_ff  <= '0;
      end else if (advance) begin
         if (in_data_ff.last) begin
            phase_ff <= PhSpace;
            neg_ff   <= 1'b0;
            acc_ff   <= '0;
            base_ff  <= '0;
            pz_ff    <= 1'b0;
            pos_ff   <= '0;
            stop_ff  <= '0;
         end else begin
            phase_ff <= phase_in;
            neg_ff   <= neg_in;
            acc_ff   <= acc_in;
            base_ff  <= base_in;
            pz_ff    <= pz_in;
            pos_ff   <= pos_in;
            stop_ff  <= stop_in;
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && in_data_ff.last) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance && in_data_ff.last) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

FILE: rtl/stia_char_class.sv
module stia_char_class
   import stia_pkg::*;
(
   input  logic [CharWidth-1:0] ch,
   output char_class_type       cls
);

   logic [CharWidth-1:0] off;

   // Digit value: 0-9, then letters of either case from 10 up
   always_comb begin
      off = '0;
      cls.digit = DigitNone;
      if (ch >= ChZero && ch <= ChNine) begin
         off = ch - ChZero;
         cls.digit = off[BaseWidth-1:0];
      end else if (ch >= ChUpA && ch <= ChUpZ) begin
         off = ch - ChUpA + 8'd10;
         cls.digit = off[BaseWidth-1:0];
      end else if (ch >= ChLoA && ch <= ChLoZ) begin
         off = ch - ChLoA + 8'd10;
         cls.digit = off[BaseWidth-1:0];
      end
   end

   // Punctuation and prefix letters
   assign cls.is_white = (ch == ChSpace) || (ch >= ChTab && ch <= ChCr);
   assign cls.is_plus  = (ch == ChPlus);
   assign cls.is_minus = (ch == ChMinus);
   assign cls.is_zero  = (ch == ChZero);
   assign cls.is_x     = (ch == ChLoX) || (ch == ChUpX);
   assign cls.is_b     = (ch == ChLoB) || (ch == ChUpB);

endmodule
